@@ src/hru_pkg.sv @@
// ----------------------------------------------------------------------------
// hru_pkg: shared types and constants for the reading-to-units converter
// Word layouts, channel constants and the fan divider state record.
// ----------------------------------------------------------------------------
`default_nettype none

package hru_pkg;

  // Input and output words
  typedef struct packed {
    logic [3:0] sensor_index;
    logic [7:0] raw_reading;
  } in_t;

  typedef struct packed {
    logic [28:0] value_micro;
    logic        reading_valid;
  } out_t;

  // Register map (word index)
  localparam logic [2:0] REG_AIN1_MODE    = 3'd0;
  localparam logic [2:0] REG_AIN2_MODE    = 3'd1;
  localparam logic [2:0] REG_TEMP2_MODE   = 3'd2;
  localparam logic [2:0] REG_VCC5_MODE    = 3'd3;
  localparam logic [2:0] REG_EXT1_ABSENT  = 3'd4;
  localparam logic [2:0] REG_FAN1_DIV_SEL = 3'd5;
  localparam logic [2:0] REG_FAN2_DIV_SEL = 3'd6;

  // Sensor channels
  localparam logic [3:0] CH_2V5   = 4'd0;
  localparam logic [3:0] CH_VCCP1 = 4'd1;
  localparam logic [3:0] CH_VCC   = 4'd2;
  localparam logic [3:0] CH_5V    = 4'd3;
  localparam logic [3:0] CH_12V   = 4'd4;
  localparam logic [3:0] CH_VCCP2 = 4'd5;
  localparam logic [3:0] CH_EXT_T = 4'd6;
  localparam logic [3:0] CH_INT_T = 4'd7;
  localparam logic [3:0] CH_FAN1  = 4'd8;
  localparam logic [3:0] CH_FAN2  = 4'd9;

  // Conversion kinds
  localparam logic [1:0] KIND_VOLT = 2'd0;
  localparam logic [1:0] KIND_TEMP = 2'd1;
  localparam logic [1:0] KIND_FAN  = 2'd2;

  // Full scales in micro-volts; temperature uses the same multiplier
  localparam logic [23:0] FS_2V5      = 24'd2500000;
  localparam logic [23:0] FS_VCCP     = 24'd2700000;
  localparam logic [23:0] FS_3V3      = 24'd3300000;
  localparam logic [23:0] FS_5V       = 24'd5000000;
  localparam logic [23:0] FS_12V      = 24'd12000000;
  localparam logic [23:0] FS_AIN      = 24'd1870000;
  localparam logic [23:0] TEMP_SCALE  = 24'd1000000;

  localparam logic [31:0] KELVIN_OFS  = 32'd273150000;
  localparam logic [31:0] NEG_CORR    = 32'd256000000;

  localparam logic [7:0] TEMP_NODATA  = 8'h80;
  localparam logic [7:0] FAN_STUCK    = 8'hFF;

  // Divide by 3 after the shift by 6: q * ceil(2^28 / 3) >> 28, exact for q < 2^27
  localparam int          RECIP3_SHIFT = 28;
  localparam logic [26:0] RECIP3       = 27'd89478486;

  // Fan divider: 21-bit numerator, restoring, seven steps per stage
  localparam int          DIV_W     = 21;
  localparam int          DIV_STEPS = 7;
  localparam logic [DIV_W-1:0] FAN_NUM = 21'd1350000;

  typedef struct packed {
    logic [7:0]       rem;
    logic [DIV_W-1:0] quo;
    logic [DIV_W-1:0] num;
    logic [7:0]       den;
  } div_t;

endpackage

`default_nettype wire

@@ src/hru_div_stage.sv @@
// ----------------------------------------------------------------------------
// hru_div_stage: one registered slice of the fan divider
// Runs a fixed number of restoring division steps and registers the result.
// ----------------------------------------------------------------------------
`default_nettype none

module hru_div_stage (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire hru_pkg::div_t d,
  output hru_pkg::div_t      q
);

  hru_pkg::div_t q_next;

  always_comb begin
    logic [8:0] rem9;
    logic       qb;
    q_next = d;
    for (int i = 0; i < hru_pkg::DIV_STEPS; i++) begin
      rem9 = {q_next.rem, q_next.num[hru_pkg::DIV_W-1]};
      qb   = 1'b0;
      if (rem9 >= {1'b0, q_next.den}) begin
        rem9 = rem9 - {1'b0, q_next.den};
        qb   = 1'b1;
      end
      q_next.rem = rem9[7:0];
      q_next.num = {q_next.num[hru_pkg::DIV_W-2:0], 1'b0};
      q_next.quo = {q_next.quo[hru_pkg::DIV_W-2:0], qb};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= q_next;
    end
  end

endmodule

`default_nettype wire

@@ src/hwmon_reading_to_units.sv @@
// ----------------------------------------------------------------------------
// hwmon_reading_to_units: raw monitor byte to micro-units
// Four-stage pipeline converting voltage, temperature and fan readings.
// ----------------------------------------------------------------------------
// Takes one word per cycle when the output side keeps up, and returns its
// result from the output register. Every word goes through the same
// four register stages: decode, full-scale multiply, divide-by-192 multiply
// and final select (the output register). The depth is set by the fan
// channel, whose 21-bit restoring division runs as three slices of seven
// steps beside the multiply path. Each stage moves forward when it is empty
// or the stage after it moves, so bubbles close up and a stalled output holds
// every word in place. Configuration sits behind an APB-style port at byte
// address 4*index; write it only while no word is in flight.
`default_nettype none

module hwmon_reading_to_units (
  input  wire logic         clk,
  input  wire logic         rst,
  // input channel
  input  wire logic         in_valid,
  output      logic         in_ready,
  input  wire hru_pkg::in_t in_word,
  // result channel
  output      logic         out_valid,
  input  wire logic         out_ready,
  output hru_pkg::out_t     out_word,
  // configuration port
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [4:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output      logic [31:0]  prdata,
  output      logic         pready
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic       ain1_mode;
  logic       ain2_mode;
  logic       temp2_mode;
  logic       vcc5_mode;
  logic       ext1_absent;
  logic [1:0] fan1_div_sel;
  logic [1:0] fan2_div_sel;

  logic       cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      ain1_mode    <= 1'b0;
      ain2_mode    <= 1'b0;
      temp2_mode   <= 1'b0;
      vcc5_mode    <= 1'b0;
      ext1_absent  <= 1'b0;
      fan1_div_sel <= 2'd1;
      fan2_div_sel <= 2'd1;
    end else if (cfg_write) begin
      // an index past the map is dropped
      case (paddr[4:2])
        hru_pkg::REG_AIN1_MODE:    ain1_mode    <= pwdata[0];
        hru_pkg::REG_AIN2_MODE:    ain2_mode    <= pwdata[0];
        hru_pkg::REG_TEMP2_MODE:   temp2_mode   <= pwdata[0];
        hru_pkg::REG_VCC5_MODE:    vcc5_mode    <= pwdata[0];
        hru_pkg::REG_EXT1_ABSENT:  ext1_absent  <= pwdata[0];
        hru_pkg::REG_FAN1_DIV_SEL: fan1_div_sel <= pwdata[1:0];
        hru_pkg::REG_FAN2_DIV_SEL: fan2_div_sel <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      hru_pkg::REG_AIN1_MODE:    prdata = {31'd0, ain1_mode};
      hru_pkg::REG_AIN2_MODE:    prdata = {31'd0, ain2_mode};
      hru_pkg::REG_TEMP2_MODE:   prdata = {31'd0, temp2_mode};
      hru_pkg::REG_VCC5_MODE:    prdata = {31'd0, vcc5_mode};
      hru_pkg::REG_EXT1_ABSENT:  prdata = {31'd0, ext1_absent};
      hru_pkg::REG_FAN1_DIV_SEL: prdata = {30'd0, fan1_div_sel};
      hru_pkg::REG_FAN2_DIV_SEL: prdata = {30'd0, fan2_div_sel};
      default:                   prdata = 32'd0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Stage advance: a stage moves when it is empty or the next one moves
  // --------------------------------------------------------------------------
  logic a_valid, b_valid, c_valid, d_valid;
  logic en_a, en_b, en_c, en_d;

  assign en_d     = !d_valid || out_ready;
  assign en_c     = !c_valid || en_d;
  assign en_b     = !b_valid || en_c;
  assign en_a     = !a_valid || en_b;
  assign in_ready = en_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      d_valid <= 1'b0;
    end else begin
      if (en_a) begin
        a_valid <= in_valid;
      end
      if (en_b) begin
        b_valid <= a_valid;
      end
      if (en_c) begin
        c_valid <= b_valid;
      end
      if (en_d) begin
        d_valid <= c_valid;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Decode: pick the conversion, the multiplier and the fan numerator
  // --------------------------------------------------------------------------
  logic [1:0]              kind_next;
  logic                    ok_next;
  logic [23:0]             fs_next;
  logic [hru_pkg::DIV_W-1:0] num_next;

  logic                    temp_ok;
  logic                    fan_ok;

  assign temp_ok = in_word.raw_reading != hru_pkg::TEMP_NODATA;
  assign fan_ok  = (in_word.raw_reading != 8'd0) &&
                   (in_word.raw_reading != hru_pkg::FAN_STUCK);

  always_comb begin
    kind_next = hru_pkg::KIND_VOLT;
    ok_next   = 1'b1;
    fs_next   = hru_pkg::TEMP_SCALE;
    num_next  = hru_pkg::FAN_NUM;
    case (in_word.sensor_index)
      hru_pkg::CH_2V5: begin
        if (temp2_mode) begin
          kind_next = hru_pkg::KIND_TEMP;
          ok_next   = temp_ok;
        end else begin
          fs_next = hru_pkg::FS_2V5;
        end
      end
      hru_pkg::CH_VCCP1: fs_next = hru_pkg::FS_VCCP;
      hru_pkg::CH_VCC:   fs_next = vcc5_mode ? hru_pkg::FS_5V : hru_pkg::FS_3V3;
      hru_pkg::CH_5V:    fs_next = hru_pkg::FS_5V;
      hru_pkg::CH_12V:   fs_next = hru_pkg::FS_12V;
      hru_pkg::CH_VCCP2: begin
        // channel goes away when channel 0 carries temperature 2
        fs_next = hru_pkg::FS_VCCP;
        ok_next = !temp2_mode;
      end
      hru_pkg::CH_EXT_T: begin
        kind_next = hru_pkg::KIND_TEMP;
        ok_next   = temp_ok && !ext1_absent;
      end
      hru_pkg::CH_INT_T: begin
        kind_next = hru_pkg::KIND_TEMP;
        ok_next   = temp_ok;
      end
      hru_pkg::CH_FAN1: begin
        if (ain1_mode) begin
          fs_next = hru_pkg::FS_AIN;
        end else begin
          // N / (raw << s) == (N >> s) / raw
          kind_next = hru_pkg::KIND_FAN;
          ok_next   = fan_ok;
          num_next  = hru_pkg::FAN_NUM >> fan1_div_sel;
        end
      end
      hru_pkg::CH_FAN2: begin
        if (ain2_mode) begin
          fs_next = hru_pkg::FS_AIN;
        end else begin
          kind_next = hru_pkg::KIND_FAN;
          ok_next   = fan_ok;
          num_next  = hru_pkg::FAN_NUM >> fan2_div_sel;
        end
      end
      default: ok_next = 1'b0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Stage A: decoded word
  // --------------------------------------------------------------------------
  logic [1:0]    a_kind;
  logic          a_ok;
  logic [23:0]   a_fs;
  logic [7:0]    a_raw;
  hru_pkg::div_t a_div;

  always_ff @(posedge clk) begin
    if (en_a) begin
      a_kind    <= kind_next;
      a_ok      <= ok_next;
      a_fs      <= fs_next;
      a_raw     <= in_word.raw_reading;
      a_div.rem <= 8'd0;
      a_div.quo <= '0;
      a_div.num <= num_next;
      a_div.den <= in_word.raw_reading;
    end
  end

  // --------------------------------------------------------------------------
  // Stage B: full-scale product, first divider slice
  // --------------------------------------------------------------------------
  logic [1:0]    b_kind;
  logic          b_ok;
  logic          b_neg;
  logic [31:0]   b_prod;
  hru_pkg::div_t b_div;

  always_ff @(posedge clk) begin
    if (en_b) begin
      b_kind <= a_kind;
      b_ok   <= a_ok;
      b_neg  <= a_raw[7];
      b_prod <= 32'(a_fs) * 32'(a_raw);
    end
  end

  hru_div_stage u_div_b (
    .clk (clk),
    .en  (en_b),
    .d   (a_div),
    .q   (b_div)
  );

  // --------------------------------------------------------------------------
  // Stage C: divide by 192 (shift by 6, then reciprocal of 3), temperature
  // offset, second divider slice
  // --------------------------------------------------------------------------
  logic [1:0]    c_kind;
  logic          c_ok;
  logic [24:0]   c_volt;
  logic [28:0]   c_temp;
  hru_pkg::div_t c_div;

  logic [52:0]   volt_prod;
  logic [31:0]   temp_sum;

  assign volt_prod = b_prod[31:6] * hru_pkg::RECIP3;
  // raw * 1e6 reads the byte unsigned; take 256e6 back off for negatives
  assign temp_sum  = b_prod + hru_pkg::KELVIN_OFS -
                     (b_neg ? hru_pkg::NEG_CORR : 32'd0);

  always_ff @(posedge clk) begin
    if (en_c) begin
      c_kind <= b_kind;
      c_ok   <= b_ok;
      c_volt <= volt_prod[52:hru_pkg::RECIP3_SHIFT];
      c_temp <= temp_sum[28:0];
    end
  end

  hru_div_stage u_div_c (
    .clk (clk),
    .en  (en_c),
    .d   (b_div),
    .q   (c_div)
  );

  // --------------------------------------------------------------------------
  // Stage D: last divider slice and output select
  // --------------------------------------------------------------------------
  hru_pkg::div_t d_div;
  logic [1:0]    d_kind;
  logic          d_ok;
  logic [24:0]   d_volt;
  logic [28:0]   d_temp;
  logic [28:0]   value_sel;

  hru_div_stage u_div_d (
    .clk (clk),
    .en  (en_d),
    .d   (c_div),
    .q   (d_div)
  );

  always_ff @(posedge clk) begin
    if (en_d) begin
      d_kind <= c_kind;
      d_ok   <= c_ok;
      d_volt <= c_volt;
      d_temp <= c_temp;
    end
  end

  always_comb begin
    case (d_kind)
      hru_pkg::KIND_VOLT: value_sel = {4'd0, d_volt};
      hru_pkg::KIND_TEMP: value_sel = d_temp;
      hru_pkg::KIND_FAN:  value_sel = {8'd0, d_div.quo};
      default:            value_sel = 29'd0;
    endcase
  end

  // drop the value of an invalid reading to zero
  assign out_valid              = d_valid;
  assign out_word.value_micro   = d_ok ? value_sel : 29'd0;
  assign out_word.reading_valid = d_ok;

endmodule

`default_nettype wire
